/* rtl/chrl_pkg.sv */
package chrl_pkg;

    localparam int PointW     = 32;
    localparam int ServerW    = 6;
    localparam int NumSrv     = 64;
    localparam int PickW      = 4;
    localparam int WantW      = 5;
    localparam int PtCountW   = 13;
    localparam int SrvCountW  = 7;
    localparam int CfgAddrW   = 1;
    localparam int CfgDataW   = 13;

    localparam logic [CfgAddrW-1:0] REG_POINT_COUNT  = 1'b0;
    localparam logic [CfgAddrW-1:0] REG_SERVER_COUNT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [11:0] entry_index;
        logic [31:0] entry_point;
        logic [5:0]  entry_server;
        logic [31:0] key_hash;
        logic [4:0]  want_count;
        logic [63:0] unavailable_mask;
    } in_item_t;

    typedef struct packed {
        logic [5:0] chosen_server;
        logic [3:0] pick_number;
        logic       last;
        logic       status;
    } out_item_t;

endpackage

/* rtl/chrl_if.sv */
interface chrl_in_if
    import chrl_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface chrl_out_if
    import chrl_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/chrl_queue.sv */
module chrl_queue
    import chrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output in_item_t out_data
);
    // Two-entry queue between the front and the back.
    in_item_t   mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/chrl_engine.sv */
module chrl_engine
    import chrl_pkg::*;
#(
    parameter int MAX_POINTS   = 4096,
    parameter int MAX_SERVERS  = 64,
    parameter int MAX_REPLICAS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    input  logic [PtCountW-1:0]  point_count,
    input  logic [SrvCountW-1:0] server_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CAP = (MAX_REPLICAS < 16) ? MAX_REPLICAS : 16;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRD   = 6'b000010,
        S_SCMP  = 6'b000100,
        S_WRD   = 6'b001000,
        S_WCHK  = 6'b010000,
        S_ERR   = 6'b100000
    } state_t;

    logic [PointW-1:0]  points_mem [MAX_POINTS];
    logic [ServerW-1:0] owners_mem [MAX_POINTS];
    logic [PointW-1:0]  pt_rd_reg;
    logic [ServerW-1:0] own_rd_reg;
    logic [AW-1:0]      rd_addr;

    state_t            state_reg;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     mid;
    logic [AW-1:0]     pos_reg;
    logic [CW-1:0]     steps_reg;
    logic [NumSrv-1:0] taken_reg;
    logic [PointW-1:0] hash_reg;
    logic [WantW-1:0]  want_reg;
    logic [WantW-1:0]  found_reg;
    logic              ovalid_reg;
    out_item_t         odata_reg;

    logic [SrvCountW-1:0] ns;
    logic [CW-1:0]        n_eff;
    logic [NumSrv-1:0]    valid_mask;
    logic [WantW-1:0]     want_sat;
    logic                 take;
    logic                 load_ok;

    always_comb
    begin
        if (point_count == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(point_count) > 32'(MAX_POINTS))
        begin
            n_eff = CW'(MAX_POINTS);
        end
        else
        begin
            n_eff = CW'(point_count);
        end
        if (server_count == '0)
        begin
            ns = SrvCountW'(1);
        end
        else if (32'(server_count) > 32'(MAX_SERVERS))
        begin
            ns = SrvCountW'(MAX_SERVERS);
        end
        else
        begin
            ns = server_count;
        end
        for (int i = 0; i < NumSrv; i++)
        begin
            valid_mask[i] = (i < 32'(ns));
        end
        if (32'(in_data.want_count) > 32'(CAP))
        begin
            want_sat = WantW'(CAP);
        end
        else
        begin
            want_sat = in_data.want_count;
        end
    end

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign take     = in_valid && in_ready;
    assign load_ok  = 32'(in_data.entry_index) < 32'(MAX_POINTS);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign rd_addr   = (state_reg == S_SRD) ? mid[AW-1:0] : pos_reg;

    always_ff @(posedge clk)
    begin
        if (take && in_data.mode == MODE_LOAD && load_ok)
        begin
            points_mem[AW'(in_data.entry_index)] <= in_data.entry_point;
            owners_mem[AW'(in_data.entry_index)] <= in_data.entry_server;
        end
        pt_rd_reg  <= points_mem[rd_addr];
        own_rd_reg <= owners_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            taken_reg  <= '0;
            n_reg      <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            pos_reg    <= '0;
            steps_reg  <= '0;
            hash_reg   <= '0;
            want_reg   <= '0;
            found_reg  <= '0;
            odata_reg  <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take && in_data.mode == MODE_QUERY)
                    begin
                        taken_reg <= (in_data.unavailable_mask & valid_mask) | ~valid_mask;
                        hash_reg  <= in_data.key_hash;
                        want_reg  <= want_sat;
                        n_reg     <= n_eff;
                        lo_reg    <= '0;
                        hi_reg    <= n_eff;
                        found_reg <= '0;
                        steps_reg <= '0;
                        if (want_sat != '0)
                        begin
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_SRD:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= S_SCMP;
                    end
                    else
                    begin
                        pos_reg   <= (lo_reg >= n_reg) ? '0 : lo_reg[AW-1:0];
                        state_reg <= S_WRD;
                    end
                end
                S_SCMP:
                begin
                    if (pt_rd_reg < hash_reg)
                    begin
                        lo_reg <= mid + CW'(1);
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_SRD;
                end
                S_WRD:
                begin
                    if (steps_reg < n_reg && found_reg < want_reg)
                    begin
                        state_reg <= S_WCHK;
                    end
                    else if (found_reg < want_reg)
                    begin
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_WCHK:
                begin
                    // A new pick waits here while the previous transfer still
                    // sits in the output register.
                    if (taken_reg[own_rd_reg] || !ovalid_reg)
                    begin
                        steps_reg <= steps_reg + CW'(1);
                        pos_reg   <= ({1'b0, pos_reg} + CW'(1) >= n_reg) ? '0 : pos_reg + AW'(1);
                        if (!taken_reg[own_rd_reg])
                        begin
                            taken_reg[own_rd_reg]   <= 1'b1;
                            odata_reg.chosen_server <= own_rd_reg;
                            odata_reg.pick_number   <= found_reg[PickW-1:0];
                            odata_reg.last          <= (found_reg + WantW'(1) == want_reg);
                            odata_reg.status        <= 1'b0;
                            found_reg  <= found_reg + WantW'(1);
                            ovalid_reg <= 1'b1;
                        end
                        state_reg <= S_WRD;
                    end
                end
                S_ERR:
                begin
                    if (!ovalid_reg)
                    begin
                        odata_reg.chosen_server <= '0;
                        odata_reg.pick_number   <= found_reg[PickW-1:0];
                        odata_reg.last          <= 1'b1;
                        odata_reg.status        <= 1'b1;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* rtl/consistent_hash_ring_lookup_top.sv */
// Flow: an item passes through the front queue; a query then runs a binary search
// (S_SRD, S_SCMP) and a ring walk (S_WRD, S_WCHK), both over one ring read port.
// A pick also waits while the previous transfer still sits in the output register.
// Throughput: loads pass at one per cycle while the output register is empty;
// a query holds the back end until its final transfer is taken.
// Reset: rst_n is asynchronous, active low; config regs reset to 1, ring undefined.
module consistent_hash_ring_lookup_top
    import chrl_pkg::*;
#(
    parameter int MAX_POINTS   = 4096,
    parameter int MAX_SERVERS  = 64,
    parameter int MAX_REPLICAS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    chrl_in_if.sink             items,
    chrl_out_if.source          results
);
    // Configuration registers, to be written only while the block is idle; the block does not enforce this.
    logic [PtCountW-1:0]  point_count_reg;
    logic [SrvCountW-1:0] server_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= PtCountW'(1);
            server_count_reg <= SrvCountW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POINT_COUNT:  point_count_reg  <= cfg_data;
                REG_SERVER_COUNT: server_count_reg <= cfg_data[SrvCountW-1:0];
                default:          ;
            endcase
        end
    end

    // The front queue takes transfers while the engine is busy with an earlier item.
    logic     q_valid;
    logic     q_ready;
    in_item_t q_data;

    chrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .in_data   (items.payload),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // The engine runs the binary search and the ring walk, with an output register.
    chrl_engine #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_SERVERS  (MAX_SERVERS),
        .MAX_REPLICAS (MAX_REPLICAS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_data      (q_data),
        .point_count  (point_count_reg),
        .server_count (server_count_reg),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_data     (results.payload)
    );
endmodule
